// File: design/frame_sequencer_loop_once_rock_core_defines.svh
// ----------------------------------------------------------------------------
// Frame sequencer assertion macros
// Shared property forms for the checker of the frame sequencer core.
// ----------------------------------------------------------------------------
`ifndef FRAME_SEQUENCER_LOOP_ONCE_ROCK_CORE_DEFINES_SVH
`define FRAME_SEQUENCER_LOOP_ONCE_ROCK_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSEQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/fseq_pkg.sv
// ----------------------------------------------------------------------------
// Frame sequencer package
// Field widths, request and response types, command, mode and register codes.
// ----------------------------------------------------------------------------
package fseq_pkg;

  localparam int MAX_FRAMES_DEF = 1024;

  localparam int CMD_W      = 3;
  localparam int AMT_W      = 16;
  localparam int ELAP_W     = 16;
  localparam int STAMP_W    = 64;
  localparam int FI_W       = 10;
  localparam int FT_W       = 11;
  localparam int MODE_W     = 2;
  localparam int PERIOD_W   = 16;
  localparam int ACC_W      = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STEP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_JUMP   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PLAY   = 3'd5;

  localparam logic [MODE_W-1:0] MODE_LOOP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ONCE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ROCK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 1'd1;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [AMT_W-1:0]   amount;
    logic [ELAP_W-1:0]         elapsed;
    logic signed [STAMP_W-1:0] stamp_in;
    logic                      play_value;
  } req_t;

  typedef struct packed {
    logic [FI_W-1:0]           frame_index;
    logic signed [STAMP_W-1:0] stamp_out;
    logic                      is_playing;
    logic                      going_forward;
    logic [FT_W-1:0]           frame_total;
  } rsp_t;

endpackage

// File: design/frame_sequencer_loop_once_rock_core.sv
// ----------------------------------------------------------------------------
// Frame sequencer core with loop, once and rock playback
// A request passes through S_EXEC, S_READ and S_RESP. A step in loop or once
// mode, a playing tick in once mode, or one in rock with one frame or no whole
// period adds one division pass; any other playing tick adds two passes.
// One request is handled at a time. Synchronous reset empties the table, stops
// playback at frame 0 going forward, and restores loop mode with period 100.
// ----------------------------------------------------------------------------
module frame_sequencer_loop_once_rock_core #(
  parameter int MAX_FRAMES = fseq_pkg::MAX_FRAMES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fseq_pkg::req_t                   in_req,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fseq_pkg::rsp_t                   out_rsp,
  input  logic                             cfg_write,
  input  logic [fseq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fseq_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fseq_pkg::*;

  // Index into the table, and a count that can also hold the full depth.
  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  // The divisor is either the frame period, the frame count or the rock cycle
  // length of twice the last index.
  localparam int DS_W = (CNT_W + 1 > PERIOD_W) ? CNT_W + 1 : PERIOD_W;
  // Working width for cursor arithmetic, with room for a sign and a carry.
  localparam int CW = ((DS_W > ACC_W) ? DS_W : ACC_W) + 2;
  localparam int DIV_CNT_W = $clog2(ACC_W);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAMES);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(ACC_W - 1);

  // Control sequencer. A request is decoded in S_EXEC, may run one or two
  // divisions through S_DIV and S_POST, then the table is read at the cursor
  // in S_READ and the response register is loaded in S_RESP.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_DIV  = 6'b000100,
    S_POST = 6'b001000,
    S_READ = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  // What the running division is for.
  typedef enum logic [2:0] {
    PH_TICK_K   = 3'b001,
    PH_TICK_POS = 3'b010,
    PH_STEP     = 3'b100
  } phase_t;

  state_t state;
  phase_t phase;
  req_t   req_r;

  // Configuration registers.
  logic [MODE_W-1:0]   play_mode;
  logic [PERIOD_W-1:0] frame_period;

  // Sequencer state held in flops; the frame timestamps live in the memory.
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] cursor;
  logic             direction;
  logic             playing;
  logic [ACC_W-1:0] accum;

  // Frame timestamp memory: one write port, one registered read port.
  logic [STAMP_W-1:0] stamp_table [MAX_FRAMES];
  logic [STAMP_W-1:0] rd_data;
  logic               tbl_we;

  // Restoring divider, one quotient bit per cycle. The dividend shifts out of
  // div_quo as the quotient shifts in; div_rem ends as the remainder.
  logic [ACC_W-1:0]     div_quo;
  logic [DS_W-1:0]      div_rem;
  logic [DS_W-1:0]      div_den;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DS_W:0]        div_shift;
  logic                 div_ge;
  logic [DS_W:0]        div_diff;

  assign div_shift = {div_rem, div_quo[ACC_W-1]};
  assign div_ge    = div_shift >= {1'b0, div_den};
  assign div_diff  = div_shift - {1'b0, div_den};

  // Shared cursor arithmetic.
  logic [CW-1:0]       cnt_w, cur_w, last_w, rock_len, rem_w, k_w, room;
  logic [ACC_W-1:0]    acc_sum;
  logic [PERIOD_W-1:0] period_eff;
  logic                amt_neg;
  logic signed [ACC_W-1:0] amt_s;
  logic [ACC_W-1:0]    amt_mag;
  logic [CW-1:0]       amt_u, jump_pos;
  logic signed [CW-1:0] rock_sum;
  logic [CW-1:0]       rock_step_pos;
  logic [CW-1:0]       fwd_sum, fwd_pos, back_pos;
  logic [CW-1:0]       phase_p, rock_q0, rock_q;
  logic                is_rock;

  assign cnt_w    = CW'(count);
  assign cur_w    = CW'(cursor);
  assign last_w   = cnt_w - CW'(1);
  assign rock_len = last_w << 1;
  assign rem_w    = CW'(div_rem);
  assign k_w      = CW'(div_quo);
  assign room     = last_w - cur_w;
  assign is_rock  = play_mode == MODE_ROCK;

  // The accumulator stays below the period it was last divided by, so the sum
  // with a 16-bit elapsed time fits in 17 bits.
  assign acc_sum    = accum + ACC_W'(req_r.elapsed);
  assign period_eff = (frame_period == '0) ? PERIOD_W'(1) : frame_period;

  assign amt_neg = req_r.amount[AMT_W-1];
  assign amt_s   = ACC_W'(req_r.amount);
  assign amt_mag = amt_neg ? ACC_W'(-amt_s) : ACC_W'(amt_s);
  assign amt_u   = CW'($unsigned(req_r.amount));

  // Jump clamps the target into the table.
  assign jump_pos = amt_neg ? '0 : ((amt_u > last_w) ? last_w : amt_u);

  // A step in rock mode moves by the signed offset and clamps at both ends.
  assign rock_sum = signed'(CW'(cursor)) + CW'(req_r.amount);
  assign rock_step_pos = (rock_sum < 0) ? '0 :
                         ((rock_sum > signed'(last_w)) ? last_w : CW'(rock_sum));

  // Forward and backward wrap by a remainder below the frame count.
  assign fwd_sum  = cur_w + rem_w;
  assign fwd_pos  = (fwd_sum >= cnt_w) ? fwd_sum - cnt_w : fwd_sum;
  assign back_pos = (cur_w >= rem_w) ? cur_w - rem_w : cur_w + cnt_w - rem_w;

  // Rock playback as a phase on a cycle of twice the last index: forward
  // positions map to themselves, backward ones to the cycle length minus the
  // cursor. The advance is the remainder plus one, at most one full cycle.
  assign phase_p = direction ? cur_w : ((cursor == '0) ? '0 : rock_len - cur_w);
  assign rock_q0 = phase_p + rem_w + CW'(1);
  assign rock_q  = (rock_q0 >= rock_len) ? rock_q0 - rock_len : rock_q0;

  // No request is taken while reset is held.
  assign in_ready = (state == S_IDLE) && !rst;
  assign tbl_we   = (state == S_EXEC) && (req_r.cmd == CMD_APPEND) && (count < MAX_CNT);

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      stamp_table[count[IDX_W-1:0]] <= req_r.stamp_in;
    end
    rd_data <= stamp_table[cursor];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_TICK_K;
      play_mode    <= MODE_LOOP;
      frame_period <= PERIOD_RESET;
      count        <= '0;
      cursor       <= '0;
      direction    <= 1'b1;
      playing      <= 1'b0;
      accum        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_PLAY_MODE:    play_mode    <= cfg_data[MODE_W-1:0];
          REG_FRAME_PERIOD: frame_period <= cfg_data[PERIOD_W-1:0];
          default: ;
        endcase
      end

      // In S_RESP the response register is handled below, where a taken
      // response is replaced by the next one in the same cycle.
      if (out_valid && out_ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_r <= in_req;
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          state <= S_READ;
          case (req_r.cmd)
            CMD_CLEAR: begin
              count   <= '0;
              cursor  <= '0;
              playing <= 1'b0;
              accum   <= '0;
            end
            CMD_APPEND: begin
              // A full table ignores the append.
              if (count < MAX_CNT) begin
                count     <= count + CNT_W'(1);
                cursor    <= '0;
                accum     <= '0;
                direction <= 1'b1;
                if (count == '0) begin
                  playing <= 1'b0;
                end
              end
            end
            CMD_TICK: begin
              if (playing && count != '0) begin
                div_quo <= acc_sum;
                div_den <= DS_W'(period_eff);
                div_rem <= '0;
                div_cnt <= '0;
                phase   <= PH_TICK_K;
                state   <= S_DIV;
              end
            end
            CMD_STEP: begin
              if (count != '0) begin
                accum <= '0;
                if (is_rock) begin
                  cursor <= IDX_W'(rock_step_pos);
                end else begin
                  div_quo <= amt_mag;
                  div_den <= DS_W'(cnt_w);
                  div_rem <= '0;
                  div_cnt <= '0;
                  phase   <= PH_STEP;
                  state   <= S_DIV;
                end
              end
            end
            CMD_JUMP: begin
              if (count != '0) begin
                cursor <= IDX_W'(jump_pos);
                accum  <= '0;
              end
            end
            CMD_PLAY: begin
              playing <= req_r.play_value;
            end
            default: ;
          endcase
        end

        S_DIV: begin
          div_quo <= {div_quo[ACC_W-2:0], div_ge};
          div_rem <= div_ge ? DS_W'(div_diff) : DS_W'(div_shift);
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_LAST) begin
            state <= S_POST;
          end
        end

        S_POST: begin
          state <= S_READ;
          case (phase)
            PH_TICK_K: begin
              // Whole periods elapsed are in the quotient; the rest stays.
              accum <= ACC_W'(div_rem);
              if (play_mode == MODE_ONCE) begin
                if (k_w > room) begin
                  cursor  <= IDX_W'(last_w);
                  playing <= 1'b0;
                end else begin
                  cursor <= IDX_W'(cur_w + k_w);
                end
              end else if (is_rock) begin
                // With a single frame or no whole period nothing moves.
                if (count > CNT_W'(1) && div_quo != '0) begin
                  div_quo <= div_quo - ACC_W'(1);
                  div_den <= DS_W'(rock_len);
                  div_rem <= '0;
                  div_cnt <= '0;
                  phase   <= PH_TICK_POS;
                  state   <= S_DIV;
                end
              end else begin
                div_den <= DS_W'(cnt_w);
                div_rem <= '0;
                div_cnt <= '0;
                phase   <= PH_TICK_POS;
                state   <= S_DIV;
              end
            end
            PH_TICK_POS: begin
              if (is_rock) begin
                if (rock_q == '0) begin
                  cursor    <= '0;
                  direction <= 1'b0;
                end else if (rock_q <= last_w) begin
                  cursor    <= IDX_W'(rock_q);
                  direction <= 1'b1;
                end else begin
                  cursor    <= IDX_W'(rock_len - rock_q);
                  direction <= 1'b0;
                end
              end else begin
                cursor <= IDX_W'(fwd_pos);
              end
            end
            PH_STEP: begin
              cursor <= amt_neg ? IDX_W'(back_pos) : IDX_W'(fwd_pos);
            end
            default: ;
          endcase
        end

        S_READ: begin
          // The table is read at the final cursor on this edge.
          state <= S_RESP;
        end

        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid                   <= 1'b1;
            out_rsp.frame_index         <= FI_W'(32'(cursor));
            out_rsp.stamp_out           <= (count != '0) ? rd_data : '0;
            out_rsp.is_playing          <= playing;
            out_rsp.going_forward       <= direction;
            out_rsp.frame_total         <= FT_W'(32'(count));
            state                       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/fseq_checker.sv
// ----------------------------------------------------------------------------
// Frame sequencer port checker
// Watches the request and response channels of the core and is bound to it.
// ----------------------------------------------------------------------------
`include "frame_sequencer_loop_once_rock_core_defines.svh"

module fseq_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input fseq_pkg::req_t in_req,
  input logic           out_valid,
  input logic           out_ready,
  input fseq_pkg::rsp_t out_rsp
);
  import fseq_pkg::*;

  // A held response keeps its value until it is taken.
  `FSEQ_ASSERT_NEXT(a_rsp_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_rsp), "response changed while stalled")

  // The core works on one request at a time.
  `FSEQ_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready, "request taken while busy")

  // An empty table reports frame zero and a zero timestamp.
  `FSEQ_ASSERT_NOW(a_empty_rsp, clk, rst, out_valid && out_rsp.frame_total == '0, out_rsp.frame_index == '0 && out_rsp.stamp_out == '0, "empty table with nonzero index or stamp")

  // The cursor always points inside a nonempty table.
  `FSEQ_ASSERT_NOW(a_index_range, clk, rst, out_valid && out_rsp.frame_total != '0, FT_W'(out_rsp.frame_index) < out_rsp.frame_total, "frame index beyond table")

endmodule

bind frame_sequencer_loop_once_rock_core fseq_checker u_fseq_checker (.*);

// File: test/tb_frame_sequencer_loop_once_rock_core.sv
// ----------------------------------------------------------------------------
// Frame sequencer core testbench
// Sends command requests and register writes to the frame sequencer, keeps its
// own copy of the playback state in a scoreboard and checks every response.
// ----------------------------------------------------------------------------
module tb_frame_sequencer_loop_once_rock_core;
  import fseq_pkg::*;

  // Command and mode codes that the package leaves unnamed. The block must
  // treat the spare commands as no-ops and the spare mode as loop.
  localparam logic [CMD_W-1:0]  CMD_RSVD_LO = 3'd6;
  localparam logic [CMD_W-1:0]  CMD_RSVD_HI = 3'd7;
  localparam logic [MODE_W-1:0] MODE_RSVD   = 2'd3;

  localparam int AMT_MIN  = -(1 << (AMT_W - 1));
  localparam int AMT_MAX  = (1 << (AMT_W - 1)) - 1;
  localparam int ELAP_MAX = (1 << ELAP_W) - 1;
  localparam logic [STAMP_W-1:0] STAMP_MAX = {1'b0, {(STAMP_W - 1){1'b1}}};
  localparam logic [STAMP_W-1:0] STAMP_MIN = {1'b1, {(STAMP_W - 1){1'b0}}};

  localparam int ITEM_TARGET   = 1900;
  localparam int FILL_PHASE    = 5;
  localparam int LONG_HOLD     = 250;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 1000000;

  // The scoreboard tracks the sequencer state on every accepted request and
  // queues the response that the block has to return for it.
  class playback_scoreboard;
    logic [STAMP_W-1:0]  stamps [MAX_FRAMES_DEF];
    logic [FT_W-1:0]     total   = '0;
    logic [FI_W-1:0]     cursor  = '0;
    logic [ACC_W-1:0]    acc     = '0;
    logic                forward = 1'b1;
    logic                playing = 1'b0;
    logic [MODE_W-1:0]   mode    = MODE_LOOP;
    logic [PERIOD_W-1:0] period  = PERIOD_RESET;
    rsp_t                expected_frames[$];
    int                  errors  = 0;
    int                  checked = 0;

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_PLAY_MODE) begin
        mode = data[MODE_W-1:0];
      end else begin
        period = data[PERIOD_W-1:0];
      end
    endfunction

    // One frame advance in rock mode, turning around at either end.
    function void bounce(int n);
      if (forward) begin
        if (cursor < n - 1) begin
          cursor++;
        end else begin
          forward = 1'b0;
          cursor--;
        end
      end else begin
        if (cursor > 0) begin
          cursor--;
        end else begin
          forward = 1'b1;
          cursor++;
        end
      end
    endfunction

    function void note_request(req_t r);
      int   n, c, a, per, k, sum, rounds;
      rsp_t want;
      n = total;
      case (r.cmd)
        CMD_CLEAR: begin
          total   = '0;
          cursor  = '0;
          playing = 1'b0;
          acc     = '0;
        end
        CMD_APPEND: begin
          if (total < MAX_FRAMES_DEF) begin
            stamps[total] = r.stamp_in;
            total++;
            cursor  = '0;
            acc     = '0;
            forward = 1'b1;
            if (total <= 1) playing = 1'b0;
          end
        end
        CMD_TICK: begin
          if (playing && n > 0) begin
            per = (period == '0) ? 1 : int'(period);
            sum = int'(acc) + int'(r.elapsed);
            k   = sum / per;
            acc = sum % per;
            c   = cursor;
            if (mode == MODE_ONCE) begin
              if (k > n - 1 - c) begin
                cursor  = n - 1;
                playing = 1'b0;
              end else begin
                cursor = c + k;
              end
            end else if (mode == MODE_ROCK) begin
              if (n > 1 && k > 0) begin
                bounce(n);
                rounds = (k - 1) % (2 * (n - 1));
                for (int i = 0; i < rounds; i++) bounce(n);
              end
            end else begin
              cursor = (c + k % n) % n;
            end
          end
        end
        CMD_STEP: begin
          if (n > 0) begin
            c = cursor;
            a = r.amount;
            if (mode == MODE_ROCK) begin
              c = c + a;
              if (c < 0) c = 0;
              if (c > n - 1) c = n - 1;
            end else begin
              c = (c + a % n + n) % n;
            end
            cursor = c;
            acc    = '0;
          end
        end
        CMD_JUMP: begin
          if (n > 0) begin
            c = r.amount;
            if (c < 0) c = 0;
            if (c > n - 1) c = n - 1;
            cursor = c;
            acc    = '0;
          end
        end
        CMD_PLAY: playing = r.play_value;
        default: ;
      endcase
      want.frame_index   = cursor;
      want.stamp_out     = (total != 0) ? stamps[cursor] : '0;
      want.is_playing    = playing;
      want.going_forward = forward;
      want.frame_total   = total;
      expected_frames.push_back(want);
    endfunction

    function void flag_field(string field, logic [STAMP_W-1:0] want, logic [STAMP_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      checked++;
      if (expected_frames.size() == 0) begin
        errors++;
        $display("%0t: response without a pending request, expected none, actual %h",
                 $time, got);
        return;
      end
      want = expected_frames.pop_front();
      if (got.frame_index !== want.frame_index)
        flag_field("frame_index", want.frame_index, got.frame_index);
      if (got.stamp_out !== want.stamp_out)
        flag_field("stamp_out", want.stamp_out, got.stamp_out);
      if (got.is_playing !== want.is_playing)
        flag_field("is_playing", want.is_playing, got.is_playing);
      if (got.going_forward !== want.going_forward)
        flag_field("going_forward", want.going_forward, got.going_forward);
      if (got.frame_total !== want.frame_total)
        flag_field("frame_total", want.frame_total, got.frame_total);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  req_t                  in_req;
  logic                  out_valid;
  logic                  out_ready;
  rsp_t                  out_rsp;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  playback_scoreboard tracker = new;
  int          requests_sent = 0;
  bit          sender_calm   = 1'b0;
  int unsigned cycle_count   = 0;

  frame_sequencer_loop_once_rock_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Watchdog. The slowest legal run is far below this count, so reaching it
  // means the block has hung or dropped a response.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic req_t make_req(logic [CMD_W-1:0] cmd, int amount, int elapsed,
                                    logic [STAMP_W-1:0] stamp, logic play);
    req_t r;
    r.cmd        = cmd;
    r.amount     = amount[AMT_W-1:0];
    r.elapsed    = elapsed[ELAP_W-1:0];
    r.stamp_in   = stamp;
    r.play_value = play;
    return r;
  endfunction

  // Offers one request after a random gap and returns at the edge where it is
  // accepted. Valid stays high into the next call, so a zero gap gives
  // back-to-back requests without a bubble.
  task automatic send_request(input req_t r);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(r);
    requests_sent++;
  endtask

  // Stops sending and waits until every pending response has come back, so
  // the block is idle before registers change.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.expected_frames.size() != 0) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges. The write enable stays high
  // across the pair so it is never lowered and raised in the same step.
  task automatic configure(input logic [CFG_DATA_W-1:0] mode_word,
                           input logic [PERIOD_W-1:0] period_word);
    cfg_write <= 1'b1;
    cfg_index <= REG_PLAY_MODE;
    cfg_data  <= mode_word;
    @(posedge clk);
    tracker.apply_register(REG_PLAY_MODE, mode_word);
    cfg_index <= REG_FRAME_PERIOD;
    cfg_data  <= period_word;
    @(posedge clk);
    tracker.apply_register(REG_FRAME_PERIOD, period_word);
    cfg_write <= 1'b0;
  endtask

  // Response side. Ready drops for a random number of cycles after each
  // response, with calm stretches where it never drops. Twice in the run it
  // holds off for a long stretch so the block backs up and stalls requests.
  initial begin : result_sink
    int hold;
    bit calm;
    hold = 0;
    calm = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        tracker.check_response(out_rsp);
        if (tracker.checked % 150 == 0) calm = ($urandom_range(0, 3) == 0);
        if (tracker.checked == 60 || tracker.checked == 1200) hold = LONG_HOLD;
        else hold = calm ? 0 : $urandom_range(0, 11);
        if (hold > 0) out_ready <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        if (hold == 0) out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    req_t                  r;
    int                    n, per, pick, phase, session_len, build, e;
    logic [MODE_W-1:0]     mode_sel;
    logic [CFG_DATA_W-1:0] mode_word;
    logic [PERIOD_W-1:0]   period_word;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_req    <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset settings (loop mode, period 100). Commands on an
    // empty table must change nothing, except that the playing flag is taken.
    send_request(make_req(CMD_TICK, 0, ELAP_MAX, '0, 1'b0));
    send_request(make_req(CMD_STEP, 5, 0, '0, 1'b0));
    send_request(make_req(CMD_JUMP, 3, 0, '0, 1'b0));
    send_request(make_req(CMD_PLAY, 0, 0, '0, 1'b1));
    send_request(make_req(CMD_TICK, 0, 400, '0, 1'b0));
    // The first append stops playback again; later ones keep it running.
    send_request(make_req(CMD_APPEND, 0, 0, STAMP_MAX, 1'b0));
    send_request(make_req(CMD_PLAY, 0, 0, '0, 1'b1));
    send_request(make_req(CMD_TICK, 0, ELAP_MAX, '0, 1'b0));
    send_request(make_req(CMD_APPEND, 0, 0, STAMP_MIN, 1'b0));
    send_request(make_req(CMD_APPEND, 0, 0, '1, 1'b0));
    // Step wraps in loop mode, jump clamps at both ends.
    send_request(make_req(CMD_STEP, AMT_MIN, 0, '0, 1'b0));
    send_request(make_req(CMD_STEP, AMT_MAX, 0, '0, 1'b0));
    send_request(make_req(CMD_JUMP, -1, 0, '0, 1'b0));
    send_request(make_req(CMD_JUMP, AMT_MAX, 0, '0, 1'b0));
    send_request(make_req(CMD_TICK, 0, 250, '0, 1'b0));
    send_request(make_req(CMD_RSVD_LO, AMT_MAX, ELAP_MAX, '1, 1'b1));
    send_request(make_req(CMD_RSVD_HI, AMT_MIN, ELAP_MAX, '1, 1'b0));
    // A tick while stopped leaves everything, the accumulator included.
    send_request(make_req(CMD_PLAY, 0, 0, '0, 1'b0));
    send_request(make_req(CMD_TICK, 0, 500, '0, 1'b0));
    send_request(make_req(CMD_CLEAR, 0, 0, '0, 1'b0));

    // Rock mode with a single frame has nowhere to go.
    drain();
    configure(MODE_ROCK, 16'd1);
    send_request(make_req(CMD_APPEND, 0, 0, {$urandom, $urandom}, 1'b0));
    send_request(make_req(CMD_PLAY, 0, 0, '0, 1'b1));
    send_request(make_req(CMD_TICK, 0, 7, '0, 1'b0));

    // Once mode with a zero period, which counts as one: a tick that runs
    // past the last frame parks there and stops playback.
    drain();
    configure(MODE_ONCE, '0);
    send_request(make_req(CMD_APPEND, 0, 0, {$urandom, $urandom}, 1'b0));
    send_request(make_req(CMD_TICK, 0, 3, '0, 1'b0));

    // Random part. Each phase drains, picks new register values and then runs
    // a session: usually a fresh table of a few frames, playback switched on
    // and a random command mix. The first phases pin the register extremes,
    // and one phase fills the table to the top and keeps appending.
    phase = 0;
    while (requests_sent < ITEM_TARGET) begin
      drain();
      case (phase)
        0: begin
          mode_sel    = MODE_ROCK;
          period_word = '1;
        end
        1: begin
          mode_sel    = MODE_RSVD;
          period_word = 16'd1;
        end
        2: begin
          mode_sel    = MODE_ONCE;
          period_word = '0;
        end
        default: begin
          case ($urandom_range(0, 9))
            0, 1, 2: mode_sel = MODE_LOOP;
            3, 4, 5: mode_sel = MODE_ONCE;
            6, 7, 8: mode_sel = MODE_ROCK;
            default: mode_sel = MODE_RSVD;
          endcase
          case ($urandom_range(0, 6))
            0:       period_word = '0;
            1:       period_word = 16'd1;
            2:       period_word = '1;
            3:       period_word = PERIOD_RESET;
            4:       period_word = $urandom_range(2, 40);
            5:       period_word = $urandom_range(41, 1000);
            default: period_word = $urandom;
          endcase
        end
      endcase
      // Upper bits of the mode word carry random junk half of the time.
      mode_word = $urandom_range(0, 1) ? $urandom : '0;
      mode_word[MODE_W-1:0] = mode_sel;
      configure(mode_word, period_word);
      sender_calm = ($urandom_range(0, 3) == 0);

      if (phase == FILL_PHASE) build = MAX_FRAMES_DEF + 3;
      else if ($urandom_range(0, 3) == 0) build = -1;
      else if ($urandom_range(0, 7) == 0) build = $urandom_range(13, 64);
      else build = $urandom_range(0, 12);

      if (build >= 0) begin
        send_request(make_req(CMD_CLEAR, $urandom, $urandom, {$urandom, $urandom}, $urandom));
        for (int i = 0; i < build; i++)
          send_request(make_req(CMD_APPEND, $urandom, $urandom, {$urandom, $urandom},
                                $urandom));
        send_request(make_req(CMD_PLAY, $urandom, $urandom, {$urandom, $urandom}, 1'b1));
      end

      session_len = $urandom_range(30, 90);
      for (int i = 0; i < session_len; i++) begin
        n   = tracker.total;
        per = (tracker.period == '0) ? 1 : int'(tracker.period);
        // Unused fields carry random content in every request.
        r    = make_req(CMD_TICK, $urandom, $urandom, {$urandom, $urandom}, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          r.cmd = CMD_APPEND;
        end else if (pick < 48) begin
          // Elapsed times cluster around whole periods so that ticks advance
          // by a few frames, with the full range mixed in.
          case ($urandom_range(0, 3))
            0:       e = $urandom_range(0, 2 * per);
            1:       e = per * int'($urandom_range(1, 2 * n + 2))
                         + int'($urandom_range(0, 2)) - 1;
            2:       e = $urandom_range(0, 3);
            default: e = $urandom_range(0, ELAP_MAX);
          endcase
          if (e > ELAP_MAX) e = ELAP_MAX;
          if (e < 0) e = 0;
          r.elapsed = e;
        end else if (pick < 63) begin
          r.cmd = CMD_STEP;
          case ($urandom_range(0, 3))
            0, 1: r.amount = int'($urandom_range(0, 4 * n + 4)) - (2 * n + 2);
            2:    ;
            default: begin
              case ($urandom_range(0, 3))
                0:       r.amount = AMT_MIN;
                1:       r.amount = AMT_MAX;
                2:       r.amount = 0;
                default: r.amount = -1;
              endcase
            end
          endcase
        end else if (pick < 73) begin
          r.cmd = CMD_JUMP;
          case ($urandom_range(0, 4))
            0, 1, 2: r.amount = $urandom_range(0, n + 2);
            3:       r.amount = -int'($urandom_range(1, 40));
            default: ;
          endcase
        end else if (pick < 88) begin
          r.cmd        = CMD_PLAY;
          r.play_value = ($urandom_range(0, 4) != 0);
        end else if (pick < 90) begin
          r.cmd = CMD_CLEAR;
        end else if (pick < 93) begin
          r.cmd = pick[0] ? CMD_RSVD_LO : CMD_RSVD_HI;
        end else begin
          // Exact multiples of the period leave the accumulator unchanged.
          e = per * int'($urandom_range(1, 4));
          r.elapsed = (e > ELAP_MAX) ? ELAP_MAX : e;
        end
        send_request(r);
      end
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_frames.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
